>>> rtl/core/nbody_gravity_accumulate_defines.svh
// Assertion macros for the gravity accumulator.
// Used at the end of the top level; needs clk and rst_n in scope.
`ifndef NBODY_GRAVITY_ACCUMULATE_DEFINES_SVH
`define NBODY_GRAVITY_ACCUMULATE_DEFINES_SVH

// Condition holds at every edge out of reset.
`define NBG_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define NBG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/nbg_pkg.sv
// Shared types and constants for the gravity accumulator.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none
package nbg_pkg;
    localparam int POS_W     = 32;
    localparam int MASS_W    = 32;
    localparam int CFG_W     = 32;
    localparam int IDX_W     = 6;
    localparam int COUNT_W   = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 2'd2;

    localparam logic [CFG_W-1:0] GRAVITY_RESET = 32'd43739;
    localparam logic [CFG_W-1:0] SCALE_RESET   = 32'd43739;

    localparam logic signed [63:0] ACC_LIM  = 64'sh2000_0000_0000_0000;
    localparam logic signed [63:0] ACC_NLIM = -64'sh2000_0000_0000_0000;

    localparam int SQRT_STEPS = 32;
    localparam int FDIV_STEPS = 62;
    localparam int QDIV_STEPS = 96;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic [MASS_W-1:0]       mass_t;
    typedef logic [IDX_W-1:0]        idx_t;

    typedef struct packed {
        pos_t  x;
        pos_t  y;
        pos_t  z;
        mass_t m;
    } body_t;
endpackage
`default_nettype wire

>>> rtl/core/nbg_channels.sv
// Valid/ready channel interfaces for request and response items.
// Depends on nbg_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface nbg_req_if import nbg_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  op;
    idx_t  body_index;
    pos_t  pos_x;
    pos_t  pos_y;
    pos_t  pos_z;
    mass_t body_mass;

    modport source (output valid, op, body_index, pos_x, pos_y, pos_z, body_mass,
                    input ready);
    modport sink (input valid, op, body_index, pos_x, pos_y, pos_z, body_mass,
                  output ready);
endinterface

interface nbg_rsp_if import nbg_pkg::*; ();
    logic valid;
    logic ready;
    pos_t accel_x;
    pos_t accel_y;
    pos_t accel_z;
    logic saturated;

    modport source (output valid, accel_x, accel_y, accel_z, saturated, input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, saturated, output ready);
endinterface
`default_nettype wire

>>> rtl/core/nbody_gravity_accumulate.sv
// Direct-sum gravitational acceleration over a body table, one shared multiplier,
// one bit-serial divider and one bit-serial square root under a sequencer.
// Depends on nbg_pkg, nbg_channels and nbody_gravity_accumulate_defines.svh.
//
//   channel  dir  payload                                      handshake
//   req      in   op, body_index, pos_x/y/z, body_mass          valid/ready
//   rsp      out  accel_x/y/z, saturated                        valid/ready
//   cfg      in   cfg_index, cfg_data                           cfg_we
//
// Write item: stored in the table on accept. Query: bodies below the count are walked,
// skipping the target and coincident ones; each summed body takes 32 root steps and,
// per axis, a 62-step and a 96-step divide. Ready returns as the result is presented.
// Reset clears control and config; the table is undefined until written.
// Ready is low while a query runs; a result held in the rsp register stalls the next at emit.
`timescale 1ns / 1ps
`default_nettype none
`include "nbody_gravity_accumulate_defines.svh"
module nbody_gravity_accumulate import nbg_pkg::*; #(
    parameter int MAX_BODIES = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    nbg_req_if.sink              req,
    nbg_rsp_if.source            rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);
    localparam int AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
    localparam int NW = ($clog2(MAX_BODIES + 1) > COUNT_W) ? $clog2(MAX_BODIES + 1)
                                                          : COUNT_W;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_TGT   = 5'd1;
    localparam logic [4:0] ST_NEXT  = 5'd2;
    localparam logic [4:0] ST_LOADJ = 5'd3;
    localparam logic [4:0] ST_R2    = 5'd4;
    localparam logic [4:0] ST_PM    = 5'd5;
    localparam logic [4:0] ST_SQRT  = 5'd6;
    localparam logic [4:0] ST_FLOAD = 5'd7;
    localparam logic [4:0] ST_FDIV  = 5'd8;
    localparam logic [4:0] ST_MULA  = 5'd9;
    localparam logic [4:0] ST_MULB  = 5'd10;
    localparam logic [4:0] ST_QLOAD = 5'd11;
    localparam logic [4:0] ST_QDIV  = 5'd12;
    localparam logic [4:0] ST_ACCUM = 5'd13;
    localparam logic [4:0] ST_FMA   = 5'd14;
    localparam logic [4:0] ST_FMB   = 5'd15;
    localparam logic [4:0] ST_FOUT  = 5'd16;
    localparam logic [4:0] ST_EMIT  = 5'd17;

    logic [4:0]           state_reg, state_next;
    logic [CFG_W-1:0]     gravity_reg, scale_reg;
    logic [COUNT_W-1:0]   count_reg;

    body_t                mem [MAX_BODIES];
    body_t                rd_body_reg;
    logic [AW-1:0]        rd_addr;
    logic                 mem_we;

    logic [NW-1:0]        j_reg, n_reg, tgt_reg;
    pos_t                 tp_x_reg, tp_y_reg, tp_z_reg;
    logic [31:0]          u_reg [3];
    logic [2:0]           neg_reg;
    logic                 s_reg;
    mass_t                mass_reg;
    logic [63:0]          r2_reg, p_reg;
    logic [63:0]          sq_x_reg;
    logic [33:0]          sq_rem_reg;
    logic [31:0]          sq_root_reg;
    logic [6:0]           cnt_reg;
    logic [1:0]           axis_reg;
    logic [95:0]          div_num_reg, div_q_reg;
    logic [63:0]          div_rem_reg, div_den_reg;
    logic [95:0]          pf_reg;
    logic signed [63:0]   acc_reg [3];
    logic [93:0]          fp_reg;
    pos_t                 res_reg [3];
    logic                 res_sat_reg;
    logic                 rsp_valid_reg;
    pos_t                 out_x_reg, out_y_reg, out_z_reg;
    logic                 out_sat_reg;

    logic                 accept, emit_go;
    logic [NW-1:0]        idx_n, cnt_n, n_lim;
    logic                 idx_ok;
    logic signed [32:0]   d_x, d_y, d_z;
    logic [32:0]          m_x, m_y, m_z;
    logic                 s_new, skip;
    logic [31:0]          mul_a, mul_b;
    logic [63:0]          mul_p;
    logic [33:0]          sq_rt, sq_trial;
    logic                 sq_ge;
    logic [64:0]          div_rs;
    logic                 div_ge;
    logic signed [63:0]   acc_sel;
    logic [63:0]          mag64;
    logic [95:0]          qs;
    logic [63:0]          v_mag;
    logic signed [63:0]   acc_sum, acc_clamp;
    logic [69:0]          fsh, flim;
    logic                 fover;
    logic [31:0]          fm, fcomp;
    logic                 acc_ok;

    assign accept  = req.valid && req.ready;
    assign idx_n   = NW'(req.body_index);
    assign idx_ok  = idx_n < NW'(MAX_BODIES);
    assign cnt_n   = NW'(count_reg);
    assign n_lim   = (cnt_n > NW'(MAX_BODIES)) ? NW'(MAX_BODIES) : cnt_n;
    assign mem_we  = accept && (req.op == OP_WRITE) && idx_ok;
    assign rd_addr = (state_reg == ST_IDLE) ? idx_n[AW-1:0] : j_reg[AW-1:0];
    assign emit_go = (state_reg == ST_EMIT) && (!rsp_valid_reg || rsp.ready);

    assign req.ready     = (state_reg == ST_IDLE);
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.accel_x   = out_x_reg;
    assign rsp.accel_y   = out_y_reg;
    assign rsp.accel_z   = out_z_reg;
    assign rsp.saturated = out_sat_reg;

    // body table
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_n[AW-1:0]] <= '{x: req.pos_x, y: req.pos_y, z: req.pos_z,
                                    m: req.body_mass};
        end
        rd_body_reg <= mem[rd_addr];
    end

    // displacement and magnitudes of the loaded body
    always_comb
    begin
        d_x   = {rd_body_reg.x[31], rd_body_reg.x} - {tp_x_reg[31], tp_x_reg};
        d_y   = {rd_body_reg.y[31], rd_body_reg.y} - {tp_y_reg[31], tp_y_reg};
        d_z   = {rd_body_reg.z[31], rd_body_reg.z} - {tp_z_reg[31], tp_z_reg};
        m_x   = d_x[32] ? 33'(-d_x) : 33'(d_x);
        m_y   = d_y[32] ? 33'(-d_y) : 33'(d_y);
        m_z   = d_z[32] ? 33'(-d_z) : 33'(d_z);
        s_new = |{m_x[32:31], m_y[32:31], m_z[32:31]};
        skip  = (j_reg == tgt_reg) || ((d_x == '0) && (d_y == '0) && (d_z == '0));
    end

    // shared multiplier
    always_comb
    begin
        acc_sel = acc_reg[axis_reg];
        mag64   = acc_sel[63] ? 64'(-acc_sel) : 64'(acc_sel);
        unique case (state_reg)
            ST_R2:
            begin
                mul_a = u_reg[axis_reg];
                mul_b = u_reg[axis_reg];
            end
            ST_PM:
            begin
                mul_a = gravity_reg;
                mul_b = mass_reg;
            end
            ST_MULA:
            begin
                mul_a = p_reg[31:0];
                mul_b = div_q_reg[31:0];
            end
            ST_MULB:
            begin
                mul_a = p_reg[63:32];
                mul_b = div_q_reg[31:0];
            end
            ST_FMA:
            begin
                mul_a = mag64[31:0];
                mul_b = scale_reg;
            end
            ST_FMB:
            begin
                mul_a = {2'b00, mag64[61:32]};
                mul_b = scale_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // root, divide, accumulate and output steps
    always_comb
    begin
        sq_rt    = {sq_rem_reg[31:0], sq_x_reg[63:62]};
        sq_trial = {sq_root_reg, 2'b01};
        sq_ge    = sq_rt >= sq_trial;

        div_rs = {div_rem_reg, div_num_reg[95]};
        div_ge = div_rs >= {1'b0, div_den_reg};

        qs        = s_reg ? (div_q_reg >> 8) : (div_q_reg >> 6);
        v_mag     = (qs > 96'h2000_0000_0000_0000) ? 64'h2000_0000_0000_0000 : qs[63:0];
        acc_sum   = acc_sel + (neg_reg[axis_reg] ? -$signed(v_mag) : $signed(v_mag));
        acc_clamp = (acc_sum > ACC_LIM) ? ACC_LIM :
                    (acc_sum < ACC_NLIM) ? ACC_NLIM : acc_sum;

        fsh   = fp_reg[93:24];
        flim  = acc_sel[63] ? 70'h8000_0000 : 70'h7FFF_FFFF;
        fover = fsh > flim;
        fm    = fover ? flim[31:0] : fsh[31:0];
        fcomp = acc_sel[63] ? 32'(-fm) : fm;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.op == OP_QUERY))
                begin
                    state_next = idx_ok ? ST_TGT : ST_EMIT;
                end
            end
            ST_TGT:   state_next = ST_NEXT;
            ST_NEXT:  state_next = (j_reg >= n_reg) ? ST_FMA : ST_LOADJ;
            ST_LOADJ: state_next = skip ? ST_NEXT : ST_R2;
            ST_R2:    state_next = (axis_reg == 2'd2) ? ST_PM : ST_R2;
            ST_PM:    state_next = ST_SQRT;
            ST_SQRT:  state_next = (cnt_reg == 7'(SQRT_STEPS - 1)) ? ST_FLOAD : ST_SQRT;
            ST_FLOAD: state_next = ST_FDIV;
            ST_FDIV:  state_next = (cnt_reg == 7'(FDIV_STEPS - 1)) ? ST_MULA : ST_FDIV;
            ST_MULA:  state_next = ST_MULB;
            ST_MULB:  state_next = ST_QLOAD;
            ST_QLOAD: state_next = ST_QDIV;
            ST_QDIV:  state_next = (cnt_reg == 7'(QDIV_STEPS - 1)) ? ST_ACCUM : ST_QDIV;
            ST_ACCUM: state_next = (axis_reg == 2'd2) ? ST_NEXT : ST_FLOAD;
            ST_FMA:   state_next = ST_FMB;
            ST_FMB:   state_next = ST_FOUT;
            ST_FOUT:  state_next = (axis_reg == 2'd2) ? ST_EMIT : ST_FMA;
            ST_EMIT:  state_next = emit_go ? ST_IDLE : ST_EMIT;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gravity_reg   <= GRAVITY_RESET;
            scale_reg     <= SCALE_RESET;
            count_reg     <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            axis_reg      <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            acc_reg       <= '{default: '0};
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_GRAVITY: gravity_reg <= cfg_data;
                    REG_SCALE:   scale_reg   <= cfg_data;
                    REG_COUNT:   count_reg   <= cfg_data[COUNT_W-1:0];
                    default:     ;
                endcase
            end

            if (emit_go)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    j_reg   <= '0;
                    n_reg   <= n_lim;
                    acc_reg <= '{default: '0};
                end
                ST_NEXT:  axis_reg <= '0;
                ST_LOADJ:
                begin
                    if (skip)
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                ST_R2:    axis_reg <= (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
                ST_PM:    cnt_reg <= '0;
                ST_SQRT:  cnt_reg <= (cnt_reg == 7'(SQRT_STEPS - 1)) ? 7'd0 : cnt_reg + 7'd1;
                ST_FLOAD: cnt_reg <= '0;
                ST_FDIV:  cnt_reg <= cnt_reg + 7'd1;
                ST_QLOAD: cnt_reg <= '0;
                ST_QDIV:  cnt_reg <= cnt_reg + 7'd1;
                ST_ACCUM:
                begin
                    acc_reg[axis_reg] <= acc_clamp;
                    if (axis_reg == 2'd2)
                    begin
                        axis_reg <= '0;
                        j_reg    <= j_reg + 1'b1;
                    end
                    else
                    begin
                        axis_reg <= axis_reg + 2'd1;
                    end
                end
                ST_FOUT:  axis_reg <= (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
                default:  ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            out_x_reg   <= res_reg[0];
            out_y_reg   <= res_reg[1];
            out_z_reg   <= res_reg[2];
            out_sat_reg <= res_sat_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                tgt_reg     <= idx_n;
                res_reg     <= '{default: '0};
                res_sat_reg <= 1'b0;
            end
            ST_TGT:
            begin
                tp_x_reg <= rd_body_reg.x;
                tp_y_reg <= rd_body_reg.y;
                tp_z_reg <= rd_body_reg.z;
            end
            ST_LOADJ:
            begin
                s_reg    <= s_new;
                neg_reg  <= {d_z[32], d_y[32], d_x[32]};
                u_reg[0] <= s_new ? m_x[32:1] : m_x[31:0];
                u_reg[1] <= s_new ? m_y[32:1] : m_y[31:0];
                u_reg[2] <= s_new ? m_z[32:1] : m_z[31:0];
                mass_reg <= rd_body_reg.m;
                r2_reg   <= '0;
            end
            ST_R2:    r2_reg <= r2_reg + mul_p;
            ST_PM:
            begin
                p_reg       <= mul_p;
                sq_x_reg    <= r2_reg;
                sq_rem_reg  <= '0;
                sq_root_reg <= '0;
            end
            ST_SQRT:
            begin
                sq_x_reg    <= {sq_x_reg[61:0], 2'b00};
                sq_rem_reg  <= sq_ge ? (sq_rt - sq_trial) : sq_rt;
                sq_root_reg <= {sq_root_reg[30:0], sq_ge};
            end
            ST_FLOAD:
            begin
                div_num_reg <= {u_reg[axis_reg], 64'd0};
                div_den_reg <= {32'd0, sq_root_reg};
                div_rem_reg <= '0;
                div_q_reg   <= '0;
            end
            ST_QLOAD:
            begin
                div_num_reg <= pf_reg;
                div_den_reg <= r2_reg;
                div_rem_reg <= '0;
                div_q_reg   <= '0;
            end
            ST_FDIV, ST_QDIV:
            begin
                div_num_reg <= {div_num_reg[94:0], 1'b0};
                div_rem_reg <= div_ge ? 64'(div_rs - {1'b0, div_den_reg}) : div_rs[63:0];
                div_q_reg   <= {div_q_reg[94:0], div_ge};
            end
            ST_MULA:  pf_reg <= {32'd0, mul_p};
            ST_MULB:  pf_reg <= pf_reg + {mul_p, 32'd0};
            ST_FMA:   fp_reg <= {30'd0, mul_p};
            ST_FMB:   fp_reg <= fp_reg + {mul_p[61:0], 32'd0};
            ST_FOUT:
            begin
                res_reg[axis_reg] <= fcomp;
                res_sat_reg       <= res_sat_reg | fover;
            end
            default:  ;
        endcase
    end

    assign acc_ok = (acc_reg[0] <= ACC_LIM) && (acc_reg[0] >= ACC_NLIM) &&
                    (acc_reg[1] <= ACC_LIM) && (acc_reg[1] >= ACC_NLIM) &&
                    (acc_reg[2] <= ACC_LIM) && (acc_reg[2] >= ACC_NLIM);

    `NBG_ASSERT_HOLDS(a_acc_bound, acc_ok, "accumulator beyond limit")
    `NBG_ASSERT_HOLDS(a_walk_bound, (state_reg == ST_IDLE) || (j_reg <= n_reg), "body walk past count")
    `NBG_ASSERT_NEXT(a_emit, emit_go, rsp_valid_reg && (state_reg == ST_IDLE), "result not presented")
endmodule
`default_nettype wire

>>> tb/nbody_gravity_accumulate_test.sv
// Self-checking testbench for nbody_gravity_accumulate: directed rows, then
// random body writes and queries under varying config and handshake idling.
// Depends on nbg_pkg, nbg_channels and the nbody_gravity_accumulate RTL.
`timescale 1ns / 1ps
module nbody_gravity_accumulate_test;
    import nbg_pkg::*;

    localparam int  TABLE_DEPTH = 64;
    localparam int  CYCLE_LIMIT = 4000000;
    localparam int  SETTLE      = 40;
    localparam int  HOLD_LEN    = 20000;
    localparam int  PHASE_ITEMS = 17;

    typedef struct {
        pos_t x;
        pos_t y;
        pos_t z;
        logic sat;
    } accel_t;

    typedef enum {ROW_WRITE, ROW_QUERY, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t kind;
        int        index;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] m;
        bit        zero_expected;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    nbg_req_if req_ch ();
    nbg_rsp_if rsp_ch ();

    nbody_gravity_accumulate dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    body_t        body_shadow [TABLE_DEPTH];
    logic [31:0]  gravity_shadow;
    logic [31:0]  scale_shadow;
    logic [6:0]   count_shadow;
    accel_t       accel_expected [$];
    stim_row_t    rows [$];
    int           send_idle;
    int           recv_idle;
    int           mismatches;
    int           cycles;
    bit           hold_request;
    bit           hold_active;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("nbody_gravity_accumulate regression: fail");
            $finish;
        end
    end

    function automatic logic signed [63:0] widen(pos_t v);
        logic signed [63:0] w;
        w = {{32{v[31]}}, v};
        return w;
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic accel_t gravity_on(idx_t tgt);
        logic signed [63:0] acc [3];
        logic signed [63:0] dv [3];
        logic [63:0]  u [3];
        logic [63:0]  mx, r2, r, gm, f, v, mag, lim, m;
        logic [127:0] q, p;
        int           n, s;
        bit           neg;
        accel_t       res;
        for (int a = 0; a < 3; a++)
            acc[a] = 0;
        n = (count_shadow > TABLE_DEPTH) ? TABLE_DEPTH : count_shadow;
        for (int j = 0; j < n; j++)
        begin
            if (j == tgt)
                continue;
            dv[0] = widen(body_shadow[j].x) - widen(body_shadow[tgt].x);
            dv[1] = widen(body_shadow[j].y) - widen(body_shadow[tgt].y);
            dv[2] = widen(body_shadow[j].z) - widen(body_shadow[tgt].z);
            if (dv[0] == 0 && dv[1] == 0 && dv[2] == 0)
                continue;
            mx = 0;
            for (int a = 0; a < 3; a++)
            begin
                u[a] = (dv[a] < 0) ? -dv[a] : dv[a];
                if (u[a] > mx)
                    mx = u[a];
            end
            s = (mx >= (64'd1 << 31)) ? 1 : 0;
            r2 = 0;
            for (int a = 0; a < 3; a++)
            begin
                u[a] = u[a] >> s;
                r2 = r2 + u[a] * u[a];
            end
            r = floor_sqrt(r2);
            if (r == 0)
                continue;
            gm = {32'd0, gravity_shadow} * {32'd0, body_shadow[j].m};
            for (int a = 0; a < 3; a++)
            begin
                f = (u[a] << 30) / r;
                q = ({64'd0, gm} * {64'd0, f}) / {64'd0, r2};
                q = q >> (6 + 2 * s);
                v = (q > {64'd0, ACC_LIM}) ? ACC_LIM : q[63:0];
                acc[a] = (dv[a] < 0) ? acc[a] - $signed(v) : acc[a] + $signed(v);
                if (acc[a] > ACC_LIM)
                    acc[a] = ACC_LIM;
                if (acc[a] < ACC_NLIM)
                    acc[a] = ACC_NLIM;
            end
        end
        res.sat = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            neg = acc[a] < 0;
            mag = neg ? -acc[a] : acc[a];
            p = ({64'd0, mag} * {96'd0, scale_shadow}) >> 24;
            lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
            if (p > {64'd0, lim})
            begin
                m = lim;
                res.sat = 1'b1;
            end
            else
                m = p[63:0];
            m = neg ? -m : m;
            case (a)
                0: res.x = m[31:0];
                1: res.y = m[31:0];
                default: res.z = m[31:0];
            endcase
        end
        return res;
    endfunction

    // Hold off the receiver for a long stretch once requested.
    initial
    begin
        hold_active = 1'b0;
        wait (hold_request);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_active <= 1'b0;
    end

    // Receive side: check each result, idle at random, honor long hold-offs.
    always @(posedge clk)
    begin
        accel_t want;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (accel_expected.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result x=%h y=%h z=%h sat=%b", rsp_ch.accel_x,
                             rsp_ch.accel_y, rsp_ch.accel_z, rsp_ch.saturated);
            end
            else
            begin
                want = accel_expected.pop_front();
                if (rsp_ch.accel_x !== want.x || rsp_ch.accel_y !== want.y ||
                    rsp_ch.accel_z !== want.z || rsp_ch.saturated !== want.sat)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("mismatch exp x=%h y=%h z=%h sat=%b got x=%h y=%h z=%h sat=%b",
                                 want.x, want.y, want.z, want.sat, rsp_ch.accel_x,
                                 rsp_ch.accel_y, rsp_ch.accel_z, rsp_ch.saturated);
                end
            end
        end
        if (hold_active)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_item(logic op, idx_t idx, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, logic [31:0] m, bit zero_expected);
        accel_t zero;
        while ($urandom_range(99) < send_idle)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op <= op;
        req_ch.body_index <= idx;
        req_ch.pos_x <= x;
        req_ch.pos_y <= y;
        req_ch.pos_z <= z;
        req_ch.body_mass <= m;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (op == OP_WRITE)
        begin
            body_shadow[idx].x = x;
            body_shadow[idx].y = y;
            body_shadow[idx].z = z;
            body_shadow[idx].m = m;
        end
        else if (zero_expected)
        begin
            zero = '{x: '0, y: '0, z: '0, sat: 1'b0};
            accel_expected = {accel_expected, zero};
        end
        else
            accel_expected = {accel_expected, gravity_on(idx)};
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [31:0] data);
        req_ch.valid <= 1'b0;
        while (accel_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            REG_GRAVITY: gravity_shadow = data;
            REG_SCALE: scale_shadow = data;
            default: count_shadow = data[6:0];
        endcase
    endtask

    task automatic add_row(row_kind_t kind, int index, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z, logic [31:0] m, bit zero_expected);
        stim_row_t row;
        row = '{kind, index, x, y, z, m, zero_expected};
        rows = {rows, row};
    endtask

    function automatic logic [31:0] random_pos();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
            2: return ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return body_shadow[0].x;
        endcase
    endfunction

    function automatic logic [31:0] random_reg();
        case ($urandom_range(3))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return GRAVITY_RESET;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [31:0] px;
        req_ch.valid = 1'b0;
        req_ch.op = OP_WRITE;
        req_ch.body_index = '0;
        req_ch.pos_x = '0;
        req_ch.pos_y = '0;
        req_ch.pos_z = '0;
        req_ch.body_mass = '0;
        hold_request = 1'b0;
        gravity_shadow = GRAVITY_RESET;
        scale_shadow = SCALE_RESET;
        count_shadow = '0;
        send_idle = 23;
        recv_idle = 55;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(ROW_WRITE, 0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0);
        add_row(ROW_QUERY, 0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1);
        add_row(ROW_WRITE, 1, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 1'b0);
        add_row(ROW_WRITE, 2, 32'h0, 32'h0, 32'h0, 32'h0000_0001, 1'b0);
        add_row(ROW_WRITE, 3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_row(ROW_WRITE, 4, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0);
        add_row(ROW_CFG, REG_COUNT, 32'd5, 32'd0, 32'd0, 32'd0, 1'b0);
        add_row(ROW_QUERY, 0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        add_row(ROW_QUERY, 1, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        add_row(ROW_QUERY, 3, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        add_row(ROW_QUERY, 4, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        add_row(ROW_CFG, REG_GRAVITY, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        add_row(ROW_QUERY, 1, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1);
        add_row(ROW_CFG, REG_GRAVITY, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 1'b0);
        add_row(ROW_CFG, REG_SCALE, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 1'b0);
        add_row(ROW_QUERY, 0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        add_row(ROW_QUERY, 2, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        add_row(ROW_CFG, REG_SCALE, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        add_row(ROW_QUERY, 3, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1);
        add_row(ROW_CFG, REG_COUNT, 32'd2, 32'd0, 32'd0, 32'd0, 1'b0);
        add_row(ROW_CFG, REG_SCALE, SCALE_RESET, 32'd0, 32'd0, 32'd0, 1'b0);
        add_row(ROW_CFG, REG_GRAVITY, GRAVITY_RESET, 32'd0, 32'd0, 32'd0, 1'b0);
        add_row(ROW_QUERY, 4, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
                write_reg(CFG_IDX_W'(rows[i].index), rows[i].x);
            else
                send_item(rows[i].kind == ROW_QUERY ? OP_QUERY : OP_WRITE,
                          idx_t'(rows[i].index), rows[i].x, rows[i].y, rows[i].z,
                          rows[i].m, rows[i].zero_expected);
        end

        // Fill the whole table so any query reads defined entries.
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            px = random_pos();
            send_item(OP_WRITE, idx_t'(i), px, random_pos(), random_pos(),
                      $urandom_range(1) ? $urandom : $urandom_range(32'h0010_0000), 1'b0);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 23 : (phase == 1) ? 55 : 0;
            recv_idle = (phase == 0) ? 55 : (phase == 1) ? 23 : 0;
            for (int sub = 0; sub < 3; sub++)
            begin
                write_reg(REG_GRAVITY, random_reg());
                write_reg(REG_SCALE, random_reg());
                write_reg(REG_COUNT, $urandom_range(8));
                if (phase == 0 && sub == 0)
                    hold_request = 1'b1;
                for (int k = 0; k < PHASE_ITEMS; k++)
                begin
                    if ($urandom_range(1))
                        send_item(OP_QUERY, idx_t'($urandom_range(TABLE_DEPTH - 1)), $urandom,
                                  $urandom, $urandom, $urandom, 1'b0);
                    else
                    begin
                        px = random_pos();
                        send_item(OP_WRITE, idx_t'($urandom_range(TABLE_DEPTH - 1)), px,
                                  random_pos(), random_pos(), $urandom, 1'b0);
                    end
                end
            end
            write_reg(REG_COUNT, (phase == 1) ? 32'd127 : 32'd64);
            send_item(OP_QUERY, idx_t'($urandom_range(TABLE_DEPTH - 1)), 32'd0, 32'd0,
                      32'd0, 32'd0, 1'b0);
        end

        req_ch.valid <= 1'b0;
        while (accel_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && accel_expected.size() == 0)
            $display("nbody_gravity_accumulate regression: pass");
        else
            $display("nbody_gravity_accumulate regression: fail");
        $finish;
    end
endmodule
